>>> hdl/dsa_pkg.sv
package dsa_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int OFFSET_BITS = 32;

  localparam int WORD_W = 32;
  localparam int PEAK_W = 33;
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  // room for top + top + size without overflow
  localparam int WIDE_W = ((OFFSET_BITS > WORD_W) ? OFFSET_BITS : WORD_W) + 2;

  typedef logic [OFFSET_BITS-1:0] off_t;
  typedef logic [WORD_W-1:0]      word_t;
  typedef logic [PEAK_W-1:0]      peak_t;
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [ADDR_W-1:0]      addr_t;
  typedef logic [WIDE_W-1:0]      wide_t;

  typedef enum logic [2:0] {
    ACT_RES_FWD  = 3'd0,
    ACT_REL_FWD  = 3'd1,
    ACT_RES_REV  = 3'd2,
    ACT_REL_REV  = 3'd3,
    ACT_ROLLBACK = 3'd4,
    ACT_CLEAR    = 3'd5
  } action_t;

  typedef enum logic [2:0] {
    STS_OK       = 3'd0,
    STS_NO_SPACE = 3'd1,
    STS_EMPTY    = 3'd2,
    STS_MISMATCH = 3'd3,
    STS_NO_MARK  = 3'd4,
    STS_FULL     = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SUM,
    S_FIT,
    S_PUSH,
    S_PEAK,
    S_ROFF,
    S_RCHK,
    S_READ,
    S_POP,
    S_RBCHK,
    S_FIN
  } state_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    alu_op_t op;
    wide_t   a;
    wide_t   b;
    wide_t   lim;
  } alu_req_t;

  typedef struct packed {
    wide_t res;
    logic  le;   // res <= lim, full width
    logic  eq;   // res wrapped to offset width == lim
  } alu_rsp_t;

endpackage

>>> hdl/dsa_ram.sv
module dsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    en,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                        wdata,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end
      rdata <= mem_r[addr];
    end
  end

endmodule

>>> hdl/dsa_alu.sv
module dsa_alu
  import dsa_pkg::*;
(
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  wide_t res;

  always_comb begin
    case (req.op)
      ALU_ADD: res = req.a + req.b;
      ALU_SUB: res = req.a - req.b;
      default: res = req.a + req.b;
    endcase
  end

  assign rsp.res = res;
  assign rsp.le  = (res <= req.lim);
  assign rsp.eq  = (wide_t'(res[OFFSET_BITS-1:0]) == req.lim);

endmodule

>>> hdl/double_ended_stack_allocator_core.sv
// Channel  | Ports                                              | Transfer
// ---------+----------------------------------------------------+--------------------------
// request  | start, busy, in_action, in_size, in_handle         | start && !busy
// result   | out_valid, out_status, out_offset, out_peak_total, | out_valid, one cycle
//          | out_out_of_space                                   |
// config   | cfg_we, cfg_wdata (total_size)                     | cfg_we
//
// One shared adder/subtractor under a sequencer does offset and size arithmetic. Reserve:
// sum, fit, push, peak, then a reverse offset step; release: a reverse handle check, read,
// pop; clear and full or empty rejects finish. Rollback: check; read, pop, check per block,
// at most STACK_DEPTH blocks. The result strobe comes in the cycle after the last step; busy
// stays high until then. Synchronous reset clears control state but sets fail_r; stack RAMs
// are not cleared. The receiver cannot stall; each result is presented for exactly one cycle.
module double_ended_stack_allocator_core
  import dsa_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  logic [2:0]    in_action,
  input  logic [31:0]   in_size,
  input  logic [31:0]   in_handle,
  output logic          out_valid,
  output logic [2:0]    out_status,
  output logic [31:0]   out_offset,
  output logic [32:0]   out_peak_total,
  output logic          out_out_of_space,
  input  logic          cfg_we,
  input  logic [31:0]   cfg_wdata
);

  state_t  state_r, state_nxt;
  action_t act_r, act_nxt;
  status_t sts_r, sts_nxt;
  word_t   total_r;
  word_t   size_r, size_nxt;
  word_t   handle_r, handle_nxt;
  wide_t   acc_r, acc_nxt;
  off_t    ftop_r, ftop_nxt, rtop_r, rtop_nxt;
  off_t    fpeak_r, fpeak_nxt, rpeak_r, rpeak_nxt;
  cnt_t    fcnt_r, fcnt_nxt, rcnt_r, rcnt_nxt;
  logic    fail_r, fail_nxt;
  logic    before_r, before_nxt;
  word_t   offset_r, offset_nxt;

  logic    out_valid_r, out_valid_nxt;
  status_t out_status_r, out_status_nxt;
  word_t   out_offset_r, out_offset_nxt;
  peak_t   out_peak_r, out_peak_nxt;
  logic    out_oos_r, out_oos_nxt;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  logic    fram_en, fram_we, rram_en, rram_we;
  addr_t   fram_addr, rram_addr;
  word_t   fram_rdata, rram_rdata;

  logic    side_rev;
  off_t    top_sel;
  off_t    peak_sel;
  word_t   rdata_sel;
  cnt_t    fcnt_m1, rcnt_m1;
  action_t in_act;

  assign in_act    = action_t'(in_action);
  assign side_rev  = (act_r == ACT_RES_REV) || (act_r == ACT_REL_REV);
  assign top_sel   = side_rev ? rtop_r : ftop_r;
  assign peak_sel  = side_rev ? rpeak_r : fpeak_r;
  assign rdata_sel = side_rev ? rram_rdata : fram_rdata;
  assign fcnt_m1   = fcnt_r - cnt_t'(1);
  assign rcnt_m1   = rcnt_r - cnt_t'(1);

  dsa_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  dsa_ram #(.WIDTH(WORD_W), .DEPTH(STACK_DEPTH)) u_fwd_ram (
    .clk   (clk),
    .en    (fram_en),
    .we    (fram_we),
    .addr  (fram_addr),
    .wdata (size_r),
    .rdata (fram_rdata)
  );

  dsa_ram #(.WIDTH(WORD_W), .DEPTH(STACK_DEPTH)) u_rev_ram (
    .clk   (clk),
    .en    (rram_en),
    .we    (rram_we),
    .addr  (rram_addr),
    .wdata (size_r),
    .rdata (rram_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    act_nxt        = act_r;
    sts_nxt        = sts_r;
    size_nxt       = size_r;
    handle_nxt     = handle_r;
    acc_nxt        = acc_r;
    ftop_nxt       = ftop_r;
    rtop_nxt       = rtop_r;
    fpeak_nxt      = fpeak_r;
    rpeak_nxt      = rpeak_r;
    fcnt_nxt       = fcnt_r;
    rcnt_nxt       = rcnt_r;
    fail_nxt       = fail_r;
    before_nxt     = before_r;
    offset_nxt     = offset_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_offset_nxt = out_offset_r;
    out_peak_nxt   = out_peak_r;
    out_oos_nxt    = out_oos_r;
    alu_req.op     = ALU_ADD;
    alu_req.a      = '0;
    alu_req.b      = '0;
    alu_req.lim    = '0;
    fram_en        = 1'b0;
    fram_we        = 1'b0;
    fram_addr      = fcnt_m1[ADDR_W-1:0];
    rram_en        = 1'b0;
    rram_we        = 1'b0;
    rram_addr      = rcnt_m1[ADDR_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (start) begin
          act_nxt    = in_act;
          size_nxt   = in_size;
          handle_nxt = in_handle;
          sts_nxt    = STS_OK;
          offset_nxt = '0;
          state_nxt  = S_FIN;
          case (in_act)
            ACT_RES_FWD, ACT_RES_REV: begin
              if (((in_act == ACT_RES_FWD) ? fcnt_r : rcnt_r) == cnt_t'(STACK_DEPTH)) begin
                sts_nxt  = STS_FULL;
                fail_nxt = 1'b1;
              end else begin
                state_nxt = S_SUM;
              end
            end
            ACT_REL_FWD: begin
              if (fcnt_r == '0) sts_nxt = STS_EMPTY;
              else state_nxt = S_READ;
            end
            ACT_REL_REV: begin
              if (rcnt_r == '0) sts_nxt = STS_EMPTY;
              else state_nxt = S_RCHK;
            end
            ACT_ROLLBACK: begin
              before_nxt = (fcnt_r != '0);
              state_nxt  = S_RBCHK;
            end
            ACT_CLEAR: begin
              ftop_nxt  = '0;
              rtop_nxt  = '0;
              fcnt_nxt  = '0;
              rcnt_nxt  = '0;
              fpeak_nxt = '0;
              rpeak_nxt = '0;
              fail_nxt  = 1'b0;
            end
            default: ;
          endcase
        end
      end
      S_SUM: begin
        alu_req.a = wide_t'(ftop_r);
        alu_req.b = wide_t'(rtop_r);
        acc_nxt   = alu_rsp.res;
        state_nxt = S_FIT;
      end
      S_FIT: begin
        alu_req.a   = acc_r;
        alu_req.b   = wide_t'(size_r);
        alu_req.lim = wide_t'(total_r);
        if (alu_rsp.le) begin
          state_nxt = S_PUSH;
        end else begin
          sts_nxt   = STS_NO_SPACE;
          fail_nxt  = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_PUSH: begin
        alu_req.a = wide_t'(top_sel);
        alu_req.b = wide_t'(size_r);
        if (side_rev) begin
          rram_en   = 1'b1;
          rram_we   = 1'b1;
          rram_addr = rcnt_r[ADDR_W-1:0];
          rcnt_nxt  = rcnt_r + cnt_t'(1);
          rtop_nxt  = alu_rsp.res[OFFSET_BITS-1:0];
        end else begin
          fram_en    = 1'b1;
          fram_we    = 1'b1;
          fram_addr  = fcnt_r[ADDR_W-1:0];
          fcnt_nxt   = fcnt_r + cnt_t'(1);
          ftop_nxt   = alu_rsp.res[OFFSET_BITS-1:0];
          offset_nxt = word_t'(ftop_r);
        end
        state_nxt = S_PEAK;
      end
      S_PEAK: begin
        if (peak_sel < top_sel) begin
          if (side_rev) rpeak_nxt = rtop_r;
          else fpeak_nxt = ftop_r;
        end
        state_nxt = side_rev ? S_ROFF : S_FIN;
      end
      S_ROFF: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = wide_t'(total_r);
        alu_req.b  = wide_t'(rtop_r);
        offset_nxt = word_t'(alu_rsp.res[OFFSET_BITS-1:0]);
        state_nxt  = S_FIN;
      end
      S_RCHK: begin
        alu_req.op  = ALU_SUB;
        alu_req.a   = wide_t'(total_r);
        alu_req.b   = wide_t'(rtop_r);
        alu_req.lim = wide_t'(handle_r);
        if (alu_rsp.eq) begin
          state_nxt = S_READ;
        end else begin
          sts_nxt   = STS_MISMATCH;
          state_nxt = S_FIN;
        end
      end
      S_READ: begin
        if (side_rev) rram_en = 1'b1;
        else fram_en = 1'b1;
        state_nxt = S_POP;
      end
      S_POP: begin
        alu_req.op  = ALU_SUB;
        alu_req.a   = wide_t'(top_sel);
        alu_req.b   = wide_t'(rdata_sel);
        alu_req.lim = wide_t'(handle_r);
        state_nxt   = S_FIN;
        if (side_rev) begin
          rtop_nxt = alu_rsp.res[OFFSET_BITS-1:0];
          rcnt_nxt = rcnt_m1;
        end else if (act_r == ACT_REL_FWD && !alu_rsp.eq) begin
          sts_nxt = STS_MISMATCH;
        end else begin
          ftop_nxt = alu_rsp.res[OFFSET_BITS-1:0];
          fcnt_nxt = fcnt_m1;
          if (act_r == ACT_ROLLBACK) state_nxt = S_RBCHK;
        end
      end
      S_RBCHK: begin
        if (fcnt_r == '0 || wide_t'(ftop_r) == wide_t'(size_r)) begin
          if (before_r && fcnt_r == '0 && size_r != '0) sts_nxt = STS_NO_MARK;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_READ;
        end
      end
      S_FIN: begin
        alu_req.a      = wide_t'(fpeak_r);
        alu_req.b      = wide_t'(rpeak_r);
        out_valid_nxt  = 1'b1;
        out_status_nxt = sts_r;
        out_offset_nxt = offset_r;
        out_peak_nxt   = peak_t'(alu_rsp.res);
        out_oos_nxt    = fail_r;
        state_nxt      = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      act_r       <= ACT_CLEAR;
      sts_r       <= STS_OK;
      total_r     <= '0;
      ftop_r      <= '0;
      rtop_r      <= '0;
      fpeak_r     <= '0;
      rpeak_r     <= '0;
      fcnt_r      <= '0;
      rcnt_r      <= '0;
      fail_r      <= 1'b1;
      before_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      act_r       <= act_nxt;
      sts_r       <= sts_nxt;
      ftop_r      <= ftop_nxt;
      rtop_r      <= rtop_nxt;
      fpeak_r     <= fpeak_nxt;
      rpeak_r     <= rpeak_nxt;
      fcnt_r      <= fcnt_nxt;
      rcnt_r      <= rcnt_nxt;
      fail_r      <= fail_nxt;
      before_r    <= before_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        total_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    size_r       <= size_nxt;
    handle_r     <= handle_nxt;
    acc_r        <= acc_nxt;
    offset_r     <= offset_nxt;
    out_status_r <= out_status_nxt;
    out_offset_r <= out_offset_nxt;
    out_peak_r   <= out_peak_nxt;
    out_oos_r    <= out_oos_nxt;
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_offset       = out_offset_r;
  assign out_peak_total   = out_peak_r;
  assign out_out_of_space = out_oos_r;

  a_strobe_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_FIN))
    else $error("result strobe without a finishing step");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted request did not make the block busy");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fcnt_r <= cnt_t'(STACK_DEPTH) && rcnt_r <= cnt_t'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_fail_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STS_NO_SPACE || out_status == STS_FULL)
      |-> out_out_of_space)
    else $error("failed reserve without out-of-space flag");

endmodule
